FILE: design/iflt_pkg.sv
// shared constants and control types for the in-flight request latency table
package iflt_pkg;

  localparam int MAX_CPUS        = 8;
  localparam int SLOTS_PER_TABLE = 64;
  localparam int QUEUE_TYPES     = 3;
  localparam int TOTAL_SLOTS     = MAX_CPUS * QUEUE_TYPES * SLOTS_PER_TABLE;
  localparam int ADDR_W          = $clog2(TOTAL_SLOTS);
  localparam int SLOT_W          = (SLOTS_PER_TABLE > 2) ? $clog2(SLOTS_PER_TABLE) : 1;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_FULL       = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
  localparam logic [2:0] ST_ZERO_START = 3'd3;
  localparam logic [2:0] ST_BAD_CPU    = 3'd4;
  localparam logic [2:0] ST_BAD_TYPE   = 3'd5;
  localparam logic [2:0] ST_ZERO_ID    = 3'd6;

  localparam logic [3:0] ACTIVE_CPUS_RST = 4'd8;

  typedef struct packed {
    logic clr_en;
    logic cap_en;
    logic check;
    logic scan_en;
    logic resp;
  } iflt_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic rej;
    logic scan_done;
  } iflt_stat_t;

endpackage

FILE: design/iflt_ram.sv
// generic simple dual-port ram with registered read
module iflt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/iflt_datapath.sv
// datapath: request capture, checks, slot scan, result and write-back
module iflt_datapath
  import iflt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  iflt_cmd_t   cmd,
  output iflt_stat_t  stat,
  input  logic        in_action,
  input  logic [63:0] in_request_id,
  input  logic [2:0]  in_cpu_index,
  input  logic [1:0]  in_queue_type,
  input  logic [63:0] in_now_us,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  output logic [2:0]  out_status,
  output logic [63:0] out_latency_us,
  output logic [5:0]  out_slot_index
);

  logic [3:0]        active_r;
  logic              action_r;
  logic [63:0]       id_r;
  logic [2:0]        cpu_r;
  logic [1:0]        qtype_r;
  logic [63:0]       now_r;
  logic [ADDR_W-1:0] base_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [SLOT_W-1:0] issue_cnt_r;
  logic [SLOT_W-1:0] cmp_slot_r;
  logic              cmp_valid_r;
  logic              wr_pend_r;
  logic [ADDR_W-1:0] wr_addr_r;
  logic [2:0]        status_r;
  logic [63:0]       latency_r;
  logic [5:0]        slot_r;

  logic [2:0]        rej_code;
  logic              rej;
  logic [63:0]       key;
  logic [63:0]       rd_id;
  logic [63:0]       rd_time;
  logic              hit;
  logic              last;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] ram_waddr;
  logic              id_we;
  logic              time_we;
  logic [63:0]       id_wdata;
  logic [63:0]       time_wdata;

  always_comb begin
    rej_code = ST_OK;
    rej      = 1'b1;
    priority if (({1'b0, cpu_r} >= active_r) || (32'(cpu_r) >= 32'(MAX_CPUS))) begin
      rej_code = ST_BAD_CPU;
    end else if (qtype_r >= 2'(QUEUE_TYPES)) begin
      rej_code = ST_BAD_TYPE;
    end else if (id_r == 64'd0) begin
      rej_code = ST_ZERO_ID;
    end else begin
      rej = 1'b0;
    end
  end

  assign key  = action_r ? id_r : 64'd0;
  assign hit  = cmp_valid_r && (rd_id == key);
  assign last = cmp_valid_r && (cmp_slot_r == SLOT_W'(SLOTS_PER_TABLE - 1));

  assign stat.clr_last  = (clr_cnt_r == ADDR_W'(TOTAL_SLOTS - 1));
  assign stat.rej       = rej;
  assign stat.scan_done = cmd.scan_en && (hit || last);

  assign rd_addr    = base_r + ADDR_W'(issue_cnt_r);
  assign ram_waddr  = cmd.clr_en ? clr_cnt_r : wr_addr_r;
  assign id_we      = cmd.clr_en || (cmd.resp && wr_pend_r);
  assign time_we    = cmd.clr_en || (cmd.resp && wr_pend_r && !action_r);
  assign id_wdata   = (cmd.clr_en || action_r) ? 64'd0 : id_r;
  assign time_wdata = cmd.clr_en ? 64'd0 : now_r;

  iflt_ram #(.WIDTH(64), .DEPTH(TOTAL_SLOTS)) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (ram_waddr),
    .wdata (id_wdata),
    .raddr (rd_addr),
    .rdata (rd_id)
  );

  iflt_ram #(.WIDTH(64), .DEPTH(TOTAL_SLOTS)) u_time_ram (
    .clk   (clk),
    .we    (time_we),
    .waddr (ram_waddr),
    .wdata (time_wdata),
    .raddr (rd_addr),
    .rdata (rd_time)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= ACTIVE_CPUS_RST;
      clr_cnt_r   <= '0;
      cmp_valid_r <= 1'b0;
      wr_pend_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        active_r <= cfg_wr_data;
      end
      if (cmd.clr_en) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      if (cmd.check) begin
        cmp_valid_r <= 1'b0;
        wr_pend_r   <= 1'b0;
      end else if (cmd.scan_en) begin
        cmp_valid_r <= 1'b1;
        if (hit) begin
          wr_pend_r <= !action_r ? 1'b1 : (rd_time != 64'd0);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      action_r <= in_action;
      id_r     <= in_request_id;
      cpu_r    <= in_cpu_index;
      qtype_r  <= in_queue_type;
      now_r    <= in_now_us;
    end
    if (cmd.check) begin
      base_r      <= ADDR_W'((32'(cpu_r) * 32'(QUEUE_TYPES) + 32'(qtype_r))
                             * 32'(SLOTS_PER_TABLE));
      issue_cnt_r <= '0;
      status_r    <= rej_code;
      latency_r   <= 64'd0;
      slot_r      <= 6'd0;
    end else if (cmd.scan_en) begin
      issue_cnt_r <= issue_cnt_r + SLOT_W'(1);
      cmp_slot_r  <= issue_cnt_r;
      if (hit) begin
        wr_addr_r <= base_r + ADDR_W'(cmp_slot_r);
        if (!action_r) begin
          status_r <= ST_OK;
          slot_r   <= 6'(cmp_slot_r);
        end else if (rd_time == 64'd0) begin
          status_r <= ST_ZERO_START;
        end else begin
          status_r  <= ST_OK;
          latency_r <= now_r - rd_time;
          slot_r    <= 6'(cmp_slot_r);
        end
      end else if (last) begin
        status_r <= action_r ? ST_NOT_FOUND : ST_FULL;
      end
    end
  end

  assign out_status     = status_r;
  assign out_latency_us = latency_r;
  assign out_slot_index = slot_r;

endmodule

FILE: design/iflt_ctrl.sv
// controller state machine: clear pass, capture, check, scan, respond
module iflt_ctrl
  import iflt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  iflt_stat_t stat,
  output iflt_cmd_t  cmd,
  output logic       busy,
  output logic       out_valid
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_CHECK = 5'b00100,
    S_SCAN  = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (stat.clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_CHECK;
      S_CHECK: state_nxt = stat.rej ? S_RESP : S_SCAN;
      S_SCAN:  if (stat.scan_done) state_nxt = S_RESP;
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.clr_en  = (state_r == S_CLEAR);
  assign cmd.cap_en  = (state_r == S_IDLE) && start;
  assign cmd.check   = (state_r == S_CHECK);
  assign cmd.scan_en = (state_r == S_SCAN);
  assign cmd.resp    = (state_r == S_RESP);
  assign busy        = (state_r != S_IDLE);
  assign out_valid   = (state_r == S_RESP);

endmodule

FILE: design/inflight_request_latency_table.sv
// top level of the in-flight request latency table
// A request is taken when start is high and busy is low; it carries
// in_action (0 start, 1 completion), in_request_id, in_cpu_index,
// in_queue_type and in_now_us. Each request gives exactly one result,
// shown for one cycle with out_valid high: out_status, out_latency_us and
// out_slot_index. The receiver cannot stall; the result must be taken then.
// Rejected requests (bad cpu, bad type, zero id) go from the check state
// straight to the result. Other requests scan their 64-slot table in
// the slot memory, one slot per cycle with the compare in the cycle
// after the read, and stop at the first match or when no slot matches.
// The write-back to the slot memory shares the result cycle. busy is
// low again the cycle after the result, so a new request is taken only
// after the previous result.
// After reset a clearing pass writes zero to all 1536 slots, one per
// cycle, with busy high throughout; cfg_wr_en and cfg_wr_data set
// the number of active cpus (reset value 8) at any time, taking effect
// for requests checked afterwards.
module inflight_request_latency_table
  import iflt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [63:0] in_request_id,
  input  logic [2:0]  in_cpu_index,
  input  logic [1:0]  in_queue_type,
  input  logic [63:0] in_now_us,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [63:0] out_latency_us,
  output logic [5:0]  out_slot_index,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data
);

  iflt_cmd_t  cmd;
  iflt_stat_t stat;

  iflt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  iflt_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_action      (in_action),
    .in_request_id  (in_request_id),
    .in_cpu_index   (in_cpu_index),
    .in_queue_type  (in_queue_type),
    .in_now_us      (in_now_us),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_status     (out_status),
    .out_latency_us (out_latency_us),
    .out_slot_index (out_slot_index)
  );

endmodule
